// ----- hdl/sensor_change_event_serializer_defines.svh -----
// assertion macros shared by the sensor change event serializer modules
// no dependencies; each macro expands to nothing when NO_ASSERTIONS is set
`ifndef SENSOR_CHANGE_EVENT_SERIALIZER_DEFINES_SVH
`define SENSOR_CHANGE_EVENT_SERIALIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SCES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sces check failed");

// next-cycle implication, checked out of reset
`define SCES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sces check failed");

`else

`define SCES_ASSERT_NOW(label, clk, rst, ante, cons)
`define SCES_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/sces_pkg.sv -----
// shared types and constants of the sensor change event serializer
// used by sces_front, sces_queue, sces_back and the top level
package sces_pkg;

   localparam int SensorsPerByte = 8;
   localparam int ModuleWidth    = 3;
   localparam int ByteWidth      = 8;
   localparam int SensorWidth    = 5;
   // rising first byte, rising second byte, falling first byte, falling second byte
   localparam int MaskWidth      = 4 * SensorsPerByte;
   localparam int MaskIdxWidth   = $clog2(MaskWidth);
   localparam int QueueDepth     = 2;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);

   // one classified report waiting for the back end
   typedef struct packed {
      logic [ModuleWidth-1:0] module_index;
      logic [MaskWidth-1:0]   change_mask;
   } queue_entry_type;

   // front end to queue
   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   // queue to front end and back end
   typedef struct packed {
      logic            full;
      logic            not_empty;
      queue_entry_type head;
   } queue_status_type;

endpackage

// ----- hdl/sensor_change_event_serializer.sv -----
// Sensor change event serializer. Each report word carries one module's two
// sensor bytes; it is compared with that module's stored report and one event
// word leaves per changed sensor: newly active sensors of the first byte, then of
// the second byte, then newly inactive sensors of the first and second byte,
// lowest bit first in each group, with tlast on the final event of the report.
// A report is classified combinationally in the front end and queued as a change
// mask (two entries deep); the back end walks that mask one set bit per cycle
// while rsp_tready does not stall the output. Reports without changes, and
// reports for a module index at or above NUM_MODULES, produce no event; the
// latter also leave the store untouched. The store is cleared by reset.
// depends on sces_pkg, sces_front, sces_queue and sces_back
module sensor_change_event_serializer #(
   parameter int NUM_MODULES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // module_index [2:0], first_byte [10:3], second_byte [18:11], zero fill
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_module [2:0], sensor_number [7:3]
   output logic [7:0]  rsp_tdata,
   // released [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   import sces_pkg::*;

   queue_push_type         queue_push;
   queue_status_type       queue_status;
   logic                   queue_pop;
   logic [ModuleWidth-1:0] event_module;
   logic [SensorWidth-1:0] sensor_number;

   sces_front #(
      .NUM_MODULES(NUM_MODULES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_module_index (req_tdata[2:0]),
      .req_first_byte   (req_tdata[10:3]),
      .req_second_byte  (req_tdata[18:11]),
      .queue_status     (queue_status),
      .queue_push       (queue_push)
   );

   sces_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .queue_push   (queue_push),
      .queue_pop    (queue_pop),
      .queue_status (queue_status)
   );

   sces_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_status      (queue_status),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_event_module  (event_module),
      .rsp_sensor_number (sensor_number),
      .rsp_released      (rsp_tuser),
      .rsp_last_event    (rsp_tlast)
   );

   assign rsp_tdata = {sensor_number, event_module};

endmodule

// ----- hdl/sces_front.sv -----
// front end: takes report words, compares against the per-module store
// and pushes a change mask to the queue; depends on sces_pkg
module sces_front #(
   parameter int NUM_MODULES = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sces_pkg::ModuleWidth-1:0]     req_module_index,
   input  logic [sces_pkg::ByteWidth-1:0]       req_first_byte,
   input  logic [sces_pkg::ByteWidth-1:0]       req_second_byte,
   input  sces_pkg::queue_status_type           queue_status,
   output sces_pkg::queue_push_type             queue_push
);
   import sces_pkg::*;

   // only indexes the 3-bit field can reach are stored
   localparam int StoreDepth = (NUM_MODULES > 8) ? 8 : NUM_MODULES;
   localparam int IdxWidth   = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
   localparam logic [5:0] NumModulesLimit = 6'(NUM_MODULES);

   logic [2*ByteWidth-1:0] store_ff [StoreDepth];
   logic [2*ByteWidth-1:0] prev_report;
   logic [2*ByteWidth-1:0] new_report;
   logic [IdxWidth-1:0]    store_idx;
   logic                   in_range;
   logic                   accept;
   logic [MaskWidth-1:0]   mask;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({3'b000, req_module_index} < NumModulesLimit);
   assign store_idx = req_module_index[IdxWidth-1:0];

   // previous report of this module, second byte high
   assign prev_report = store_ff[store_idx];
   assign new_report  = {req_second_byte, req_first_byte};

   // classify changed bits into the four event groups
   assign mask = {prev_report[15:8] & ~req_second_byte,
                  prev_report[7:0]  & ~req_first_byte,
                  req_second_byte   & ~prev_report[15:8],
                  req_first_byte    & ~prev_report[7:0]};

   // push only reports that change something
   always_comb begin
      queue_push.valid              = accept && in_range && (mask != '0);
      queue_push.entry.module_index = req_module_index;
      queue_push.entry.change_mask  = mask;
   end

   // store update, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < StoreDepth; i++) begin
            store_ff[i] <= '0;
         end
      end else if (accept && in_range) begin
         store_ff[store_idx] <= new_report;
      end
   end

endmodule

// ----- hdl/sces_queue.sv -----
// short fifo between the front end and the back end
// depends on sces_pkg and the assertion macro header
`include "sensor_change_event_serializer_defines.svh"
module sces_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  sces_pkg::queue_push_type    queue_push,
   input  logic                        queue_pop,
   output sces_pkg::queue_status_type  queue_status
);
   import sces_pkg::*;

   queue_entry_type           entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]  count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   localparam logic [QueueCntWidth-1:0] DepthCount = QueueCntWidth'(QueueDepth);
   localparam logic [QueuePtrWidth-1:0] LastPtr    = QueuePtrWidth'(QueueDepth - 1);

   assign do_push = queue_push.valid && (count_ff != DepthCount);
   assign do_pop  = queue_pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= queue_push.entry;
      end
   end

   always_comb begin
      queue_status.full      = (count_ff == DepthCount);
      queue_status.not_empty = (count_ff != '0);
      queue_status.head      = entries_ff[rd_ptr_ff];
   end

   // checks
   `SCES_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DepthCount)
   `SCES_ASSERT_NOW(a_no_drop, clock, reset, queue_push.valid, count_ff != DepthCount)
   `SCES_ASSERT_NOW(a_push_nonzero, clock, reset, queue_push.valid,
                    queue_push.entry.change_mask != '0)

endmodule

// ----- hdl/sces_back.sv -----
// back end: walks one change mask, lowest set bit per cycle while the output is not stalled, into events
// depends on sces_pkg and the assertion macro header
`include "sensor_change_event_serializer_defines.svh"
module sces_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sces_pkg::queue_status_type        queue_status,
   output logic                              queue_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sces_pkg::ModuleWidth-1:0]  rsp_event_module,
   output logic [sces_pkg::SensorWidth-1:0]  rsp_sensor_number,
   output logic                              rsp_released,
   output logic                              rsp_last_event
);
   import sces_pkg::*;

   logic                    busy_ff, busy_in;
   logic [MaskWidth-1:0]    mask_ff, mask_in;
   logic [ModuleWidth-1:0]  module_ff, module_in;
   logic                    out_valid_ff, out_valid_in;
   logic [ModuleWidth-1:0]  out_module_ff, out_module_in;
   logic [SensorWidth-1:0]  out_sensor_ff, out_sensor_in;
   logic                    out_released_ff, out_released_in;
   logic                    out_last_ff, out_last_in;
   logic [MaskIdxWidth-1:0] low_idx;
   logic [MaskWidth-1:0]    rest_mask;
   logic                    slot_free;
   logic                    emit;

   // lowest set bit of the pending mask
   always_comb begin
      low_idx = '0;
      for (int i = MaskWidth - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = MaskIdxWidth'(i);
         end
      end
   end

   assign rest_mask = mask_ff & ~(MaskWidth'(1) << low_idx);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit      = busy_ff && slot_free;
   assign queue_pop = !busy_ff && queue_status.not_empty;

   // mask walk and output register
   always_comb begin
      busy_in         = busy_ff;
      mask_in         = mask_ff;
      module_in       = module_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_module_in   = out_module_ff;
      out_sensor_in   = out_sensor_ff;
      out_released_in = out_released_ff;
      out_last_in     = out_last_ff;
      if (queue_pop) begin
         busy_in   = 1'b1;
         mask_in   = queue_status.head.change_mask;
         module_in = queue_status.head.module_index;
      end else if (emit) begin
         mask_in         = rest_mask;
         busy_in         = (rest_mask != '0);
         out_valid_in    = 1'b1;
         out_module_in   = module_ff;
         // bit position within byte counts down from the sensor base
         out_sensor_in   = SensorWidth'(SensorsPerByte)
                           - {2'b00, low_idx[2:0]}
                           + (low_idx[3] ? SensorWidth'(SensorsPerByte) : '0);
         out_released_in = low_idx[4];
         out_last_in     = (rest_mask == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mask_ff         <= mask_in;
      module_ff       <= module_in;
      out_module_ff   <= out_module_in;
      out_sensor_ff   <= out_sensor_in;
      out_released_ff <= out_released_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_module  = out_module_ff;
   assign rsp_sensor_number = out_sensor_ff;
   assign rsp_released      = out_released_ff;
   assign rsp_last_event    = out_last_ff;

   // checks
   `SCES_ASSERT_NOW(a_busy_has_bits, clock, reset, busy_ff, mask_ff != '0)
   `SCES_ASSERT_NOW(a_sensor_range, clock, reset, out_valid_ff,
                    (out_sensor_ff != '0) && (out_sensor_ff <= 5'd16))
   `SCES_ASSERT_NEXT(a_last_ends_walk, clock, reset, emit && (rest_mask == '0), !busy_ff)

endmodule
